@@ rtl/lkar_pkg.sv @@
// ----------------------------------------------------------------------------
// lkar_pkg: shared types and constants of the layered key action resolver
// Holds the controller states, the action type codes, the result event codes
// and the command that the controller hands to the layer stack.
// ----------------------------------------------------------------------------
package lkar_pkg;

  // Width of one keymap action word and the split of its fields.
  localparam int ActionW      = 16;
  localparam int ActTypeShift = 12;
  localparam logic [3:0]  ActTypeMask  = 4'hF;
  localparam logic [11:0] ActValueMask = 12'h0FFF;

  // Widest layer number that the stack command can carry (up to 16 layers).
  localparam int MaxLayerW = 4;

  // Action types, taken from bits 15..12 of an action word.
  localparam logic [3:0] ActKeycode   = 4'd0;
  localparam logic [3:0] ActModifier  = 4'd1;
  localparam logic [3:0] ActMomentary = 4'd2;
  localparam logic [3:0] ActToggle    = 4'd3;
  localparam logic [3:0] ActGoto      = 4'd4;
  localparam logic [3:0] ActMedia     = 4'd5;
  localparam logic [3:0] ActSpecial   = 4'd6;

  // Value of a special action that requests a device switch.
  localparam logic [11:0] SpecialDevSwitch = 12'h001;

  // Event codes of a result beat.
  localparam logic [2:0] EvNone         = 3'd0;
  localparam logic [2:0] EvKeyPress     = 3'd1;
  localparam logic [2:0] EvKeyRelease   = 3'd2;
  localparam logic [2:0] EvMediaPress   = 3'd3;
  localparam logic [2:0] EvMediaRelease = 3'd4;
  localparam logic [2:0] EvDevSwitch    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_APPLY,
    ST_TOP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    STK_NONE,
    STK_PUSH,
    STK_POP,
    STK_TOGGLE,
    STK_GOTO
  } stack_op_e;

  typedef struct packed {
    stack_op_e              op;
    logic [MaxLayerW-1:0]   layer;
  } stack_cmd_t;

endpackage

@@ rtl/lkar_keymap_mem.sv @@
// ----------------------------------------------------------------------------
// lkar_keymap_mem: keymap table storage
// One synchronous memory of action words addressed by {layer, key}, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module lkar_keymap_mem #(
  parameter int NUM_KEYS   = 16,
  parameter int NUM_LAYERS = 8,
  localparam int KeyW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
  localparam int LayerW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1,
  localparam int AddrW  = KeyW + LayerW
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [lkar_pkg::ActionW-1:0] wdata_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [lkar_pkg::ActionW-1:0] rdata_o
);
  import lkar_pkg::*;

  localparam int Depth = 1 << AddrW;

  logic [ActionW-1:0] mem_q [Depth];
  logic [ActionW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lkar_layer_stack.sv @@
// ----------------------------------------------------------------------------
// lkar_layer_stack: duplicate-free stack of active layers
// Keeps the ordered layer list, its fill level and a presence mask, and
// carries out push, pop, toggle and go-to commands.
// ----------------------------------------------------------------------------
module lkar_layer_stack #(
  parameter int NUM_LAYERS = 8,
  localparam int LayerW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1,
  localparam int SizeW  = $clog2(NUM_LAYERS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lkar_pkg::stack_cmd_t cmd_i,
  input  logic [LayerW-1:0]    rd_idx_i,
  output logic [LayerW-1:0]    rd_layer_o,
  output logic [SizeW-1:0]     size_o
);
  import lkar_pkg::*;

  logic [LayerW-1:0]     stack_q [NUM_LAYERS];
  logic [LayerW-1:0]     stack_d [NUM_LAYERS];
  logic [SizeW-1:0]      size_q, size_d;
  logic [NUM_LAYERS-1:0] present_q, present_d;

  logic [LayerW-1:0]     layer;
  logic                  hit;
  logic                  push_en;
  logic                  pop_en;
  logic [NUM_LAYERS-1:0] shift_m;

  assign layer = cmd_i.layer[LayerW-1:0];
  assign hit   = present_q[layer];

  always_comb begin
    push_en = 1'b0;
    pop_en  = 1'b0;
    case (cmd_i.op)
      STK_PUSH:   push_en = 1'b1;
      STK_POP:    pop_en  = 1'b1;
      STK_TOGGLE: begin
        push_en = !hit;
        pop_en  = hit;
      end
      default:    ;
    endcase
  end

  // Entries at and above the popped layer move down by one place.
  always_comb begin
    logic run;
    run = 1'b0;
    for (int j = 0; j < NUM_LAYERS; j++) begin
      if ((stack_q[j] == layer) && (SizeW'(j) < size_q)) begin
        run = 1'b1;
      end
      shift_m[j] = run;
    end
  end

  always_comb begin
    stack_d   = stack_q;
    size_d    = size_q;
    present_d = present_q;
    if (cmd_i.op == STK_GOTO) begin
      present_d        = '0;
      present_d[0]     = 1'b1;
      present_d[layer] = 1'b1;
      stack_d[0]       = '0;
      for (int j = 1; j < NUM_LAYERS; j++) begin
        if (j == 1) begin
          stack_d[j] = layer;
        end
      end
      size_d = (layer != '0) ? SizeW'(2) : SizeW'(1);
    end else if (push_en) begin
      if ((size_q < SizeW'(NUM_LAYERS)) && !hit) begin
        stack_d[size_q[LayerW-1:0]] = layer;
        size_d                      = size_q + SizeW'(1);
        present_d[layer]            = 1'b1;
      end
    end else if (pop_en) begin
      if (hit) begin
        for (int j = 0; j < NUM_LAYERS - 1; j++) begin
          if (shift_m[j]) begin
            stack_d[j] = stack_q[j + 1];
          end
        end
        size_d           = size_q - SizeW'(1);
        present_d[layer] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_LAYERS; j++) begin
        stack_q[j] <= '0;
      end
      size_q    <= SizeW'(1);
      present_q <= NUM_LAYERS'(1);
    end else begin
      stack_q   <= stack_d;
      size_q    <= size_d;
      present_q <= present_d;
    end
  end

  assign rd_layer_o = stack_q[rd_idx_i];
  assign size_o     = size_q;

endmodule

@@ rtl/layered_key_action_resolver_unit.sv @@
// ----------------------------------------------------------------------------
// layered_key_action_resolver_unit: keyboard layer and keymap resolver
// Each input beat is either a keymap write or a key event, and each gives
// exactly one result beat. A write stores its action word at acceptance
// when its key and layer are in range, and then goes to the output step. A
// key event walks the active layer stack from the top down, reading one
// keymap word per cycle from the table memory, and stops at the first
// non-zero word. A hit then passes through the apply and top steps to the
// output step; a walk that finds nothing goes straight to the output step.
// A key beyond the table or an empty stack skips the walk and goes straight
// to the output step like a write. The block takes one beat at a time and
// returns to idle on the same edge that loads its result register. A stalled
// result holds the next item in its last step. The keymap memory has no
// reset: every entry that a key event can reach must be written first. The
// stack holds layer 0 after reset, and the modifier byte reads 0.
// ----------------------------------------------------------------------------
module layered_key_action_resolver_unit #(
  parameter int NUM_KEYS   = 16,
  parameter int NUM_LAYERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  key_index_i,
  input  logic        pressed_i,
  input  logic [2:0]  layer_index_i,
  input  logic [15:0] action_word_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  keycode_o,
  output logic [7:0]  modifiers_o,
  output logic [11:0] media_code_o,
  output logic [2:0]  top_layer_o
);
  import lkar_pkg::*;

  localparam int KeyW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LayerW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int SizeW  = $clog2(NUM_LAYERS + 1);
  localparam int AddrW  = KeyW + LayerW;

  state_e state_q, state_d;

  // Per-beat working registers.
  logic [KeyW-1:0]    key_q, key_d;
  logic               pressed_q, pressed_d;
  logic [LayerW-1:0]  idx_q, idx_d;
  logic [ActionW-1:0] act_q, act_d;
  logic [2:0]         ev_q, ev_d;
  logic [7:0]         kc_q, kc_d;
  logic [11:0]        media_q, media_d;

  // Architectural state outside the memories.
  logic [7:0]         mod_q, mod_d;
  logic [LayerW-1:0]  top_q, top_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_ev_q, out_ev_d;
  logic [7:0]         out_kc_q, out_kc_d;
  logic [7:0]         out_mod_q, out_mod_d;
  logic [11:0]        out_media_q, out_media_d;
  logic [2:0]         out_top_q, out_top_d;

  logic               in_acc;
  logic               out_free;
  logic               key_ok;
  logic               layer_ok;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [AddrW-1:0]   mem_raddr;
  logic [ActionW-1:0] mem_rdata;

  stack_cmd_t         stk_cmd;
  logic [LayerW-1:0]  stk_rd_layer;
  logic [SizeW-1:0]   stk_size;

  logic [3:0]         atype;
  logic [11:0]        aval;
  logic               aval_ok;

  // The block is ready for a new beat only between items; the result register
  // decouples the output side, so a waiting result does not hold the input.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Range checks of the raw input fields against the configured table size.
  assign key_ok   = ({3'b000, key_index_i} < 7'(NUM_KEYS));
  assign layer_ok = ({2'b00, layer_index_i} < 5'(NUM_LAYERS));

  // Field split of the action word found by the scan.
  assign atype   = 4'(act_q >> ActTypeShift) & ActTypeMask;
  assign aval    = act_q[11:0] & ActValueMask;
  assign aval_ok = (aval < 12'(NUM_LAYERS));

  // Writes go straight into the table at acceptance. Reads follow the stack
  // index chosen for the next cycle, so the word for idx_q arrives in the
  // cycle after it was addressed.
  assign mem_waddr = {LayerW'(layer_index_i), KeyW'(key_index_i)};
  assign mem_raddr = {stk_rd_layer, key_q};

  lkar_keymap_mem #(
    .NUM_KEYS   (NUM_KEYS),
    .NUM_LAYERS (NUM_LAYERS)
  ) u_keymap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (action_word_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lkar_layer_stack #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .rd_idx_i   (idx_d),
    .rd_layer_o (stk_rd_layer),
    .size_o     (stk_size)
  );

  // Next state. A key event that cannot hit anything (key beyond the table or
  // an empty stack) skips the scan and reports no event.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i) begin
            state_d = ST_OUT;
          end else if (key_ok && (stk_size != '0)) begin
            state_d = ST_LOOK;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_LOOK:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (mem_rdata != '0) begin
          state_d = ST_APPLY;
        end else if (idx_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_APPLY: state_d = ST_TOP;
      ST_TOP:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the controller.
  always_comb begin
    key_d       = key_q;
    pressed_d   = pressed_q;
    idx_d       = idx_q;
    act_d       = act_q;
    ev_d        = ev_q;
    kc_d        = kc_q;
    media_d     = media_q;
    mod_d       = mod_q;
    top_d       = top_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ev_d    = out_ev_q;
    out_kc_d    = out_kc_q;
    out_mod_d   = out_mod_q;
    out_media_d = out_media_q;
    out_top_d   = out_top_q;
    mem_we      = 1'b0;
    stk_cmd.op    = STK_NONE;
    stk_cmd.layer = MaxLayerW'(aval);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ev_d    = EvNone;
          kc_d    = '0;
          media_d = '0;
          if (kind_i) begin
            mem_we = key_ok && layer_ok;
          end else begin
            key_d     = KeyW'(key_index_i);
            pressed_d = pressed_i;
            idx_d     = LayerW'(stk_size - SizeW'(1));
          end
        end
      end
      ST_SCAN: begin
        // A transparent word sends the scan one layer further down.
        if (mem_rdata != '0) begin
          act_d = mem_rdata;
        end else if (idx_q != '0) begin
          idx_d = idx_q - LayerW'(1);
        end
      end
      ST_APPLY: begin
        case (atype)
          ActKeycode: begin
            ev_d = pressed_q ? EvKeyPress : EvKeyRelease;
            kc_d = aval[7:0];
          end
          ActModifier: begin
            mod_d = pressed_q ? (mod_q | aval[7:0]) : (mod_q & ~aval[7:0]);
          end
          ActMomentary: begin
            if (aval_ok) begin
              stk_cmd.op = pressed_q ? STK_PUSH : STK_POP;
            end
          end
          ActToggle: begin
            if (pressed_q && aval_ok) begin
              stk_cmd.op = STK_TOGGLE;
            end
          end
          ActGoto: begin
            if (pressed_q && aval_ok) begin
              stk_cmd.op = STK_GOTO;
            end
          end
          ActMedia: begin
            if (pressed_q) begin
              ev_d    = EvMediaPress;
              media_d = aval;
            end else begin
              ev_d = EvMediaRelease;
            end
          end
          ActSpecial: begin
            if (pressed_q && (aval == SpecialDevSwitch)) begin
              ev_d = EvDevSwitch;
            end
          end
          default: ;
        endcase
      end
      ST_TOP: begin
        // The stack has settled; its top entry becomes the reported layer.
        idx_d = LayerW'(stk_size - SizeW'(1));
        top_d = (stk_size == '0) ? '0 : stk_rd_layer;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = ev_q;
          out_kc_d    = kc_q;
          out_mod_d   = mod_q;
          out_media_d = media_q;
          out_top_d   = 3'(top_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mod_q       <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    pressed_q   <= pressed_d;
    idx_q       <= idx_d;
    act_q       <= act_d;
    ev_q        <= ev_d;
    kc_q        <= kc_d;
    media_q     <= media_d;
    out_ev_q    <= out_ev_d;
    out_kc_q    <= out_kc_d;
    out_mod_q   <= out_mod_d;
    out_media_q <= out_media_d;
    out_top_q   <= out_top_d;
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_ev_q;
  assign keycode_o    = out_kc_q;
  assign modifiers_o  = out_mod_q;
  assign media_code_o = out_media_q;
  assign top_layer_o  = out_top_q;

`ifndef SYNTHESIS
  // An accepted beat closes the input side in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted again directly after a beat");

  // The stack never holds more layers than the table has.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_size <= SizeW'(NUM_LAYERS))
    else $error("layer stack overfilled");

  // Only the apply step may change the modifier byte.
  a_mod_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_APPLY) |=> $stable(mod_q))
    else $error("modifier byte changed outside the apply step");

  // A result beat carries one of the defined event codes.
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o <= EvDevSwitch))
    else $error("undefined event code on a result beat");
`endif

endmodule
